// ===== design/bcdc_pkg.sv =====
// ----------------------------------------------------------------------------
// bcdc_pkg
// Shared types and constants of the ball color detector and classifier:
// field widths, mode and event codes, color codes and the color target table.
// ----------------------------------------------------------------------------
package bcdc_pkg;

    // Width of one sensor field on the stream and of the bits used from it
    localparam int LEVEL_W      = 16;
    localparam int CHANNEL_BITS = 16;

    // level * 100 needs seven more bits; the percentage is eight bits
    localparam int NUM_W  = CHANNEL_BITS + 7;
    localparam int PCT_W  = 8;
    localparam int HI_W   = NUM_W - PCT_W;

    // Configuration register widths and indexes
    localparam int THR_W   = 16;
    localparam int TOL_W   = 4;
    localparam int HITS_W  = 2;
    localparam int CFG_W   = 16;
    localparam int CFG_IDX_W = 2;

    localparam logic [CFG_IDX_W-1:0] REG_DETECT_THRESHOLD = 2'd0;
    localparam logic [CFG_IDX_W-1:0] REG_BAND_TOLERANCE   = 2'd1;
    localparam logic [CFG_IDX_W-1:0] REG_DETECT_HITS      = 2'd2;

    localparam logic [THR_W-1:0]  THRESHOLD_RESET = 16'd7000;
    localparam logic [TOL_W-1:0]  TOLERANCE_RESET = 4'd1;
    localparam logic [HITS_W-1:0] HITS_RESET      = 2'd2;

    // Result codes
    localparam int KIND_W  = 2;
    localparam int COLOR_W = 3;

    localparam logic [KIND_W-1:0] EV_NONE       = 2'd0;
    localparam logic [KIND_W-1:0] EV_CLASSIFIED = 2'd1;
    localparam logic [KIND_W-1:0] EV_GONE       = 2'd2;

    localparam logic [COLOR_W-1:0] COLOR_NONE = 3'd0;
    localparam logic [COLOR_W-1:0] COLOR_LAST = 3'd6;

    localparam logic [PCT_W-1:0] PCT_SAT = 8'd255;

    // Color targets as (red %, green %, blue %), in priority order:
    // red, orange, yellow, green, blue, pink
    localparam int NUM_COLORS = 6;
    localparam logic [PCT_W-1:0] COLOR_TARGET [NUM_COLORS][3] = '{
        '{8'd60, 8'd19, 8'd17},
        '{8'd58, 8'd22, 8'd14},
        '{8'd43, 8'd36, 8'd14},
        '{8'd30, 8'd44, 8'd17},
        '{8'd13, 8'd32, 8'd48},
        '{8'd48, 8'd22, 8'd26}
    };

    typedef enum logic [1:0] {
        MODE_WAIT     = 2'd0,
        MODE_DETECTED = 2'd1,
        MODE_DEPOSIT  = 2'd2
    } mode_t;

    typedef enum logic [1:0] {
        ST_IDLE  = 2'd0,
        ST_LOAD  = 2'd1,
        ST_DIV   = 2'd2,
        ST_MATCH = 2'd3
    } state_t;

endpackage

// ===== design/ball_color_detect_classifier.sv =====
// ----------------------------------------------------------------------------
// ball_color_detect_classifier
// Counts bright samples to detect a ball, classifies its color from the
// red/green/blue percentages of the clear level, then waits for it to leave.
// ----------------------------------------------------------------------------
//
//   Channel   Direction  Handshake                     Content
//   s_axis    in         s_axis_tvalid/s_axis_tready   clear, red, green, blue
//   m_axis    out        m_axis_tvalid/m_axis_tready   event kind, ball color
//   cfg       in         cfg_wr_en (no wait)           threshold, tolerance, hits
//
// A sample in the waiting or depositing mode, or with a zero clear level in
// the detected mode, gives its result in the cycle after it is accepted.
// A sample to classify runs its three percentages one after the other through
// one restoring divider, each with a load step and eight quotient bits; then
// the percentages are matched against the color targets.
// A channel whose percentage saturates skips its quotient steps.
// Reset leaves the block waiting with the hit count at zero.
// The block holds off new requests while the result register is full and
// not being taken, and while a classification is in progress.

module ball_color_detect_classifier
    import bcdc_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,

    input  logic                 s_axis_tvalid,
    output logic                 s_axis_tready,
    // clear_level[15:0], red_level[31:16], green_level[47:32], blue_level[63:48]
    input  logic [4*LEVEL_W-1:0] s_axis_tdata,

    output logic                 m_axis_tvalid,
    input  logic                 m_axis_tready,
    // ball_color[2:0], zeros[7:3]
    output logic [7:0]           m_axis_tdata,
    // event_kind[1:0]
    output logic [KIND_W-1:0]    m_axis_tuser,

    input  logic                 cfg_wr_en,
    input  logic [CFG_IDX_W-1:0] cfg_index,
    input  logic [CFG_W-1:0]     cfg_wdata
);

    // Control state
    state_t              state_reg, state_next;
    mode_t               mode_reg, mode_next;
    logic [HITS_W-1:0]   hit_count_reg, hit_count_next;
    logic [1:0]          ch_reg, ch_next;
    logic [2:0]          cnt_reg, cnt_next;
    logic                out_valid_reg, out_valid_next;

    // Configuration
    logic [THR_W-1:0]    thr_reg;
    logic [TOL_W-1:0]    tol_reg;
    logic [HITS_W-1:0]   hits_reg;

    // Payload
    logic [CHANNEL_BITS-1:0] clear_reg, clear_next;
    logic [CHANNEL_BITS-1:0] lvl_reg [3];
    logic [CHANNEL_BITS-1:0] lvl_next [3];
    logic [PCT_W-1:0]        pct_reg [3];
    logic [PCT_W-1:0]        pct_next [3];
    logic [CHANNEL_BITS-1:0] rem_reg, rem_next;
    logic [PCT_W-1:0]        sh_reg, sh_next;
    logic [KIND_W-1:0]       kind_reg, kind_next;
    logic [COLOR_W-1:0]      color_reg, color_next;

    // Datapath helpers
    logic                    slot_free;
    logic                    in_fire;
    logic [CHANNEL_BITS-1:0] in_clear;
    logic [HITS_W-1:0]       hits_inc;
    logic [NUM_W-1:0]        num;
    logic [HI_W-1:0]         num_hi;
    logic                    num_sat;
    logic [CHANNEL_BITS:0]   trial;
    logic                    qbit;
    logic [PCT_W-1:0]        sh_step;
    logic [NUM_COLORS-1:0]   color_hit;
    logic [COLOR_W-1:0]      match_color;

    function automatic logic in_band(input logic [PCT_W-1:0] pct,
                                     input logic [PCT_W-1:0] target,
                                     input logic [TOL_W-1:0] tol);
        logic [PCT_W:0] lo_sum;
        logic [PCT_W:0] hi_sum;
        lo_sum = {1'b0, pct} + (PCT_W+1)'(tol);
        hi_sum = {1'b0, target} + (PCT_W+1)'(tol);
        return (lo_sum >= {1'b0, target}) && ({1'b0, pct} <= hi_sum);
    endfunction

    assign slot_free     = !out_valid_reg || m_axis_tready;
    assign s_axis_tready = (state_reg == ST_IDLE) && slot_free;
    assign in_fire       = s_axis_tvalid && s_axis_tready;
    assign in_clear      = s_axis_tdata[CHANNEL_BITS-1:0];
    assign hits_inc      = hit_count_reg + HITS_W'(1);

    // Scale the current channel by 100 and test for a quotient of 256 or more
    always_comb
    begin
        num = (NUM_W'(lvl_reg[ch_reg]) << 6) + (NUM_W'(lvl_reg[ch_reg]) << 5)
            + (NUM_W'(lvl_reg[ch_reg]) << 2);
        num_hi  = num[NUM_W-1:PCT_W];
        num_sat = {1'b0, num_hi} >= (HI_W+1)'(clear_reg);
    end

    // One restoring step: shift in the next numerator bit, subtract if it fits
    assign trial   = {rem_reg, sh_reg[PCT_W-1]};
    assign qbit    = trial >= {1'b0, clear_reg};
    assign sh_step = {sh_reg[PCT_W-2:0], qbit};

    // Test all targets, take the first that matches
    always_comb
    begin
        for (int k = 0; k < NUM_COLORS; k++) begin
            color_hit[k] = in_band(pct_reg[0], COLOR_TARGET[k][0], tol_reg)
                        && in_band(pct_reg[1], COLOR_TARGET[k][1], tol_reg)
                        && in_band(pct_reg[2], COLOR_TARGET[k][2], tol_reg);
        end
        match_color = COLOR_NONE;
        for (int k = NUM_COLORS - 1; k >= 0; k--) begin
            if (color_hit[k]) begin
                match_color = COLOR_W'(k + 1);
            end
        end
    end

    // Next state and datapath control
    always_comb
    begin
        state_next     = state_reg;
        mode_next      = mode_reg;
        hit_count_next = hit_count_reg;
        ch_next        = ch_reg;
        cnt_next       = cnt_reg;
        out_valid_next = out_valid_reg;
        clear_next     = clear_reg;
        lvl_next       = lvl_reg;
        pct_next       = pct_reg;
        rem_next       = rem_reg;
        sh_next        = sh_reg;
        kind_next      = kind_reg;
        color_next     = color_reg;

        // Drop the result once taken
        if (m_axis_tvalid && m_axis_tready) begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_fire) begin
                    clear_next  = in_clear;
                    lvl_next[0] = s_axis_tdata[LEVEL_W +: CHANNEL_BITS];
                    lvl_next[1] = s_axis_tdata[2*LEVEL_W +: CHANNEL_BITS];
                    lvl_next[2] = s_axis_tdata[3*LEVEL_W +: CHANNEL_BITS];
                    kind_next   = EV_NONE;
                    color_next  = COLOR_NONE;
                    unique case (mode_reg)
                        MODE_DETECTED:
                        begin
                            if (in_clear != '0) begin
                                ch_next    = 2'd0;
                                state_next = ST_LOAD;
                            end else begin
                                out_valid_next = 1'b1;
                            end
                        end
                        MODE_DEPOSIT:
                        begin
                            out_valid_next = 1'b1;
                            if (THR_W'(in_clear) <= thr_reg) begin
                                kind_next = EV_GONE;
                                mode_next = MODE_WAIT;
                            end
                        end
                        default:
                        begin
                            // Count bright samples; code 3 falls back to waiting
                            out_valid_next = 1'b1;
                            mode_next      = MODE_WAIT;
                            if (THR_W'(in_clear) >= thr_reg) begin
                                if (hits_inc >= hits_reg) begin
                                    hit_count_next = '0;
                                    mode_next      = MODE_DETECTED;
                                end else begin
                                    hit_count_next = hits_inc;
                                end
                            end
                        end
                    endcase
                end
            end

            ST_LOAD:
            begin
                if (num_sat) begin
                    pct_next[ch_reg] = PCT_SAT;
                    if (ch_reg == 2'd2) begin
                        state_next = ST_MATCH;
                    end else begin
                        ch_next = ch_reg + 2'd1;
                    end
                end else begin
                    rem_next   = CHANNEL_BITS'(num_hi);
                    sh_next    = num[PCT_W-1:0];
                    cnt_next   = '0;
                    state_next = ST_DIV;
                end
            end

            ST_DIV:
            begin
                rem_next = qbit ? CHANNEL_BITS'(trial - {1'b0, clear_reg})
                                : trial[CHANNEL_BITS-1:0];
                sh_next  = sh_step;
                cnt_next = cnt_reg + 3'd1;
                if (cnt_reg == 3'd7) begin
                    pct_next[ch_reg] = sh_step;
                    if (ch_reg == 2'd2) begin
                        state_next = ST_MATCH;
                    end else begin
                        ch_next    = ch_reg + 2'd1;
                        state_next = ST_LOAD;
                    end
                end
            end

            ST_MATCH:
            begin
                // Hold the verdict until the result register frees up
                if (slot_free) begin
                    out_valid_next = 1'b1;
                    state_next     = ST_IDLE;
                    if (match_color != COLOR_NONE) begin
                        kind_next  = EV_CLASSIFIED;
                        color_next = match_color;
                        mode_next  = MODE_DEPOSIT;
                    end else begin
                        kind_next  = EV_NONE;
                        color_next = COLOR_NONE;
                    end
                end
            end

            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // Control and configuration registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            state_reg     <= ST_IDLE;
            mode_reg      <= MODE_WAIT;
            hit_count_reg <= '0;
            ch_reg        <= '0;
            cnt_reg       <= '0;
            out_valid_reg <= 1'b0;
            thr_reg       <= THRESHOLD_RESET;
            tol_reg       <= TOLERANCE_RESET;
            hits_reg      <= HITS_RESET;
        end else begin
            state_reg     <= state_next;
            mode_reg      <= mode_next;
            hit_count_reg <= hit_count_next;
            ch_reg        <= ch_next;
            cnt_reg       <= cnt_next;
            out_valid_reg <= out_valid_next;
            if (cfg_wr_en) begin
                unique case (cfg_index)
                    REG_DETECT_THRESHOLD: thr_reg  <= cfg_wdata[THR_W-1:0];
                    REG_BAND_TOLERANCE:   tol_reg  <= cfg_wdata[TOL_W-1:0];
                    REG_DETECT_HITS:      hits_reg <= cfg_wdata[HITS_W-1:0];
                    default: ;
                endcase
            end
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        clear_reg <= clear_next;
        lvl_reg   <= lvl_next;
        pct_reg   <= pct_next;
        rem_reg   <= rem_next;
        sh_reg    <= sh_next;
        kind_reg  <= kind_next;
        color_reg <= color_next;
    end

    assign m_axis_tvalid = out_valid_reg;
    assign m_axis_tuser  = kind_reg;
    assign m_axis_tdata  = {5'd0, color_reg};

endmodule

// ===== design/bcdc_checker.sv =====
// ----------------------------------------------------------------------------
// bcdc_checker
// Port-level checks on the ball color detector result stream.
// ----------------------------------------------------------------------------
module bcdc_checker
    import bcdc_pkg::*;
(
    input logic                 clk,
    input logic                 rst_n,
    input logic                 s_axis_tready,
    input logic                 m_axis_tvalid,
    input logic                 m_axis_tready,
    input logic [7:0]           m_axis_tdata,
    input logic [KIND_W-1:0]    m_axis_tuser
);

    // A color is reported only with a classification
    a_color_only_classified: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser != EV_CLASSIFIED)
            |-> m_axis_tdata[COLOR_W-1:0] == COLOR_NONE)
        else $error("color reported without classification");

    // A classification always names one of the six colors
    a_classified_color: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && m_axis_tuser == EV_CLASSIFIED)
            |-> (m_axis_tdata[COLOR_W-1:0] != COLOR_NONE
                 && m_axis_tdata[COLOR_W-1:0] <= COLOR_LAST))
        else $error("classification without a valid color");

    // Event kind code 3 never appears
    a_kind_code: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid |-> (m_axis_tuser == EV_NONE || m_axis_tuser == EV_CLASSIFIED
                           || m_axis_tuser == EV_GONE))
        else $error("unknown event kind");

    // A stalled result blocks new requests
    a_stall_blocks_input: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready) |-> !s_axis_tready)
        else $error("request taken while result stalled");

    // A stalled result holds
    a_result_holds: assert property (@(posedge clk) disable iff (!rst_n)
        (m_axis_tvalid && !m_axis_tready)
            |=> (m_axis_tvalid && $stable(m_axis_tdata) && $stable(m_axis_tuser)))
        else $error("stalled result changed");

endmodule

bind ball_color_detect_classifier bcdc_checker u_bcdc_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .s_axis_tready (s_axis_tready),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tuser  (m_axis_tuser)
);

// ===== tb/tb_ball_color_detect_classifier.sv =====
// ----------------------------------------------------------------------------
// tb_ball_color_detect_classifier
// Self-checking bench for the ball color detector and classifier. An initial
// block fills a queue of sensor samples: directed corner cases first, then
// phases of random ball passes under different register settings. A clocked
// driver sends the queue over the sample stream and predicts each result on
// acceptance. A clocked monitor compares every result with the oldest
// prediction. Both sides idle at random.
// ----------------------------------------------------------------------------

module tb_ball_color_detect_classifier
    import bcdc_pkg::*;
();

    timeunit 1ns;
    timeprecision 1ps;

    localparam int HALF_PERIOD  = 2;
    localparam int RESET_CYCLES = 11;
    localparam int CYCLE_LIMIT  = 500000;
    localparam int IDLE_PCT     = 17;
    localparam int CALM_FROM    = 1500;
    localparam int CALM_TO      = 4500;
    localparam int PHASE_ITEMS  = 180;
    localparam int SETTLE       = 40;
    localparam int MAX_REPORTS  = 10;

    // Color targets, eight bits each, from the lowest bit up:
    // red (r, g, b), orange, yellow, green, blue, pink
    localparam logic [8*18-1:0] BALL_TARGETS = {
        8'd26, 8'd22, 8'd48,
        8'd48, 8'd32, 8'd13,
        8'd17, 8'd44, 8'd30,
        8'd14, 8'd36, 8'd43,
        8'd14, 8'd22, 8'd58,
        8'd17, 8'd19, 8'd60
    };

    typedef enum logic [2:0] {
        BALL_NONE   = 3'd0,
        BALL_RED    = 3'd1,
        BALL_ORANGE = 3'd2,
        BALL_YELLOW = 3'd3,
        BALL_GREEN  = 3'd4,
        BALL_BLUE   = 3'd5,
        BALL_PINK   = 3'd6
    } ball_color_e;

    typedef struct packed {
        logic [KIND_W-1:0]  kind;
        logic [COLOR_W-1:0] color;
    } ball_event_t;

    logic                 clk = 1'b0;
    logic                 rst_n = 1'b0;
    logic                 s_axis_tvalid = 1'b0;
    logic                 s_axis_tready;
    // clear_level[15:0], red_level[31:16], green_level[47:32], blue_level[63:48]
    logic [4*LEVEL_W-1:0] s_axis_tdata = '0;
    logic                 m_axis_tvalid;
    logic                 m_axis_tready = 1'b0;
    // ball_color[2:0], zeros[7:3]
    logic [7:0]           m_axis_tdata;
    // event_kind[1:0]
    logic [KIND_W-1:0]    m_axis_tuser;
    logic                 cfg_wr_en = 1'b0;
    logic [CFG_IDX_W-1:0] cfg_index = '0;
    logic [CFG_W-1:0]     cfg_wdata = '0;

    // Register copies and state of the classifier as seen by the bench
    logic [THR_W-1:0]  thr_cfg  = THRESHOLD_RESET;
    logic [TOL_W-1:0]  tol_cfg  = TOLERANCE_RESET;
    logic [HITS_W-1:0] hits_cfg = HITS_RESET;
    mode_t             ball_mode = MODE_WAIT;
    logic [1:0]        hit_cnt = 2'd0;

    logic [4*LEVEL_W-1:0] samples_q [$];
    ball_event_t          ball_events_q [$];
    ball_event_t          want;
    int                   items_pushed = 0;
    int                   results_seen = 0;
    int                   errors = 0;
    int                   cycle_cnt = 0;

    ball_color_detect_classifier dut (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser),
        .cfg_wr_en     (cfg_wr_en),
        .cfg_index     (cfg_index),
        .cfg_wdata     (cfg_wdata)
    );

    always #(HALF_PERIOD) clk = ~clk;

    // Target percentage of color k for channel ch (0 red, 1 green, 2 blue)
    function automatic int target_pct(int k, int ch);
        return int'(BALL_TARGETS[(3*k+ch)*8 +: 8]);
    endfunction

    function automatic int pct_of(logic [15:0] lvl, logic [15:0] clr);
        int q;
        q = (int'(lvl) * 100) / int'(clr);
        return (q > 255) ? 255 : q;
    endfunction

    function automatic bit in_band(int pct, int target);
        return (pct + int'(tol_cfg) >= target) && (pct <= target + int'(tol_cfg));
    endfunction

    // Advance the classifier state by one sample and return the event it reports
    function automatic ball_event_t classify_sample(logic [4*LEVEL_W-1:0] data);
        ball_event_t ev;
        logic [15:0] clr;
        int          pr;
        int          pg;
        int          pb;
        bit          found;
        ev.kind  = EV_NONE;
        ev.color = BALL_NONE;
        clr      = data[15:0];
        found    = 1'b0;
        case (ball_mode)
            MODE_DETECTED:
            begin
                if (clr != 16'd0)
                begin
                    pr = pct_of(data[31:16], clr);
                    pg = pct_of(data[47:32], clr);
                    pb = pct_of(data[63:48], clr);
                    for (int k = 0; k < NUM_COLORS; k++)
                    begin
                        if (!found && in_band(pr, target_pct(k, 0)) &&
                            in_band(pg, target_pct(k, 1)) && in_band(pb, target_pct(k, 2)))
                        begin
                            found     = 1'b1;
                            ev.kind   = EV_CLASSIFIED;
                            ev.color  = BALL_RED + 3'(k);
                            ball_mode = MODE_DEPOSIT;
                        end
                    end
                end
            end
            MODE_DEPOSIT:
            begin
                if (clr <= thr_cfg)
                begin
                    ev.kind   = EV_GONE;
                    ball_mode = MODE_WAIT;
                end
            end
            default:
            begin
                ball_mode = MODE_WAIT;
                if (clr >= thr_cfg)
                begin
                    hit_cnt = hit_cnt + 2'd1;
                    if (hit_cnt >= hits_cfg)
                    begin
                        hit_cnt   = 2'd0;
                        ball_mode = MODE_DETECTED;
                    end
                end
            end
        endcase
        return ev;
    endfunction

    // Idle roughly one cycle in six, except inside the calm window
    function automatic bit take_break();
        if (cycle_cnt >= CALM_FROM && cycle_cnt < CALM_TO)
            return 1'b0;
        return $urandom_range(99) < IDLE_PCT;
    endfunction

    // Sample driver: hold each request until accepted, predict on acceptance
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            s_axis_tvalid <= 1'b0;
        end
        else
        begin
            if (s_axis_tvalid && s_axis_tready)
                ball_events_q.push_back(classify_sample(s_axis_tdata));
            if (!s_axis_tvalid || s_axis_tready)
            begin
                if (samples_q.size() != 0 && !take_break())
                begin
                    s_axis_tdata  <= samples_q.pop_front();
                    s_axis_tvalid <= 1'b1;
                end
                else
                begin
                    s_axis_tvalid <= 1'b0;
                end
            end
        end
    end

    // Result monitor: check each accepted result against the oldest prediction
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            m_axis_tready <= 1'b0;
        end
        else
        begin
            if (m_axis_tvalid && m_axis_tready)
            begin
                results_seen++;
                if (ball_events_q.size() == 0)
                begin
                    errors++;
                    if (errors <= MAX_REPORTS)
                        $display("result %0d unexpected: kind %0d tdata 0x%02h",
                                 results_seen, m_axis_tuser, m_axis_tdata);
                end
                else
                begin
                    want = ball_events_q.pop_front();
                    if (m_axis_tuser !== want.kind || m_axis_tdata !== {5'd0, want.color})
                    begin
                        errors++;
                        if (errors <= MAX_REPORTS)
                            $display("result %0d: exp kind %0d color %0d, got %0d 0x%02h",
                                     results_seen, want.kind, want.color,
                                     m_axis_tuser, m_axis_tdata);
                    end
                end
            end
            m_axis_tready <= !take_break();
        end
    end

    // Watchdog
    always @(posedge clk)
    begin
        cycle_cnt <= cycle_cnt + 1;
        if (cycle_cnt >= CYCLE_LIMIT)
        begin
            $display("DONE: errors detected");
            $finish;
        end
    end

    task automatic push_sample(logic [15:0] clr, logic [15:0] red, logic [15:0] green,
                               logic [15:0] blue);
        samples_q.push_back({blue, green, red, clr});
        items_pushed++;
    endtask

    // Sample at or above the threshold, random channels
    task automatic push_bright();
        push_sample(16'($urandom_range(65535, thr_cfg)), 16'($urandom), 16'($urandom),
                    16'($urandom));
    endtask

    // Sample at or below the threshold, random channels
    task automatic push_dark();
        push_sample(16'($urandom_range(thr_cfg, 0)), 16'($urandom), 16'($urandom),
                    16'($urandom));
    endtask

    // Sample whose percentages sit within the tolerance of color k; clr >= 100
    task automatic push_tinted(int k, int clr);
        int pct [3];
        int lvl [3];
        for (int ch = 0; ch < 3; ch++)
        begin
            pct[ch] = target_pct(k, ch) + int'($urandom_range(2 * int'(tol_cfg)))
                      - int'(tol_cfg);
            if (pct[ch] < 0)
                pct[ch] = 0;
            lvl[ch] = (pct[ch] * clr + 99) / 100;
        end
        push_sample(16'(clr), 16'(lvl[0]), 16'(lvl[1]), 16'(lvl[2]));
    endtask

    // One ball pass: bright samples, optional miss, the color, then removal
    task automatic push_ball(int k);
        int n;
        int clr;
        n = (hits_cfg == 2'd0) ? 1 : int'(hits_cfg);
        for (int i = 0; i < n; i++)
        begin
            push_bright();
            if (i < n - 1 && thr_cfg != 16'd0 && $urandom_range(3) == 0)
                push_dark();
        end
        if ($urandom_range(4) == 0)
            push_sample(16'($urandom_range(65535, 100)), 16'd0, 16'd0, 16'd0);
        clr = ($urandom_range(7) == 0) ? int'($urandom_range(300, 100))
                                       : int'($urandom_range(65535, 100));
        push_tinted(k, clr);
        if (thr_cfg != 16'hFFFF && $urandom_range(2) == 0)
            push_sample(16'($urandom_range(65535, int'(thr_cfg) + 1)), 16'($urandom),
                        16'($urandom), 16'($urandom));
        push_dark();
    endtask

    // Mostly well-formed ball passes, the rest noise and broken sequences
    task automatic random_phase(int budget);
        int stop_at;
        int pick;
        stop_at = items_pushed + budget;
        while (items_pushed < stop_at)
        begin
            pick = $urandom_range(99);
            if (pick < 65)
                push_ball($urandom_range(NUM_COLORS - 1));
            else if (pick < 80)
                push_sample(16'($urandom), 16'($urandom), 16'($urandom), 16'($urandom));
            else if (pick < 90)
                push_tinted($urandom_range(NUM_COLORS - 1), $urandom_range(65535, 100));
            else if (pick < 95)
                push_sample(16'd0, 16'($urandom), 16'($urandom), 16'($urandom));
            else
                push_sample(16'($urandom_range(255, 1)), 16'($urandom_range(65535, 1000)),
                            16'($urandom_range(65535, 1000)),
                            16'($urandom_range(65535, 1000)));
        end
    endtask

    // Wait until every sample is sent and every result is checked
    task automatic drain();
        do
            @(negedge clk);
        while (samples_q.size() != 0 || s_axis_tvalid || ball_events_q.size() != 0);
    endtask

    task automatic write_reg(logic [CFG_IDX_W-1:0] idx, logic [CFG_W-1:0] value);
        @(posedge clk);
        cfg_wr_en <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= value;
        case (idx)
            REG_DETECT_THRESHOLD: thr_cfg  = value[THR_W-1:0];
            REG_BAND_TOLERANCE:   tol_cfg  = value[TOL_W-1:0];
            REG_DETECT_HITS:      hits_cfg = value[HITS_W-1:0];
            default: ;
        endcase
        @(posedge clk);
        cfg_wr_en <= 1'b0;
    endtask

    task automatic run_phase(int thr, int tol, int hits);
        write_reg(REG_DETECT_THRESHOLD, CFG_W'(thr));
        write_reg(REG_BAND_TOLERANCE, CFG_W'(tol));
        write_reg(REG_DETECT_HITS, CFG_W'(hits));
        random_phase(PHASE_ITEMS);
        drain();
    endtask

    initial
    begin
        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // Directed corners under reset settings
        push_sample(16'd0, 16'd0, 16'd0, 16'd0);
        push_sample(16'd7000, 16'hFFFF, 16'd0, 16'hFFFF);
        push_sample(16'd6999, 16'd0, 16'hFFFF, 16'd0);
        push_sample(16'hFFFF, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        // zero clear level while detected, then saturated percentages
        push_sample(16'd0, 16'd5, 16'd5, 16'd5);
        push_sample(16'd1, 16'hFFFF, 16'hFFFF, 16'hFFFF);
        push_sample(16'd10000, 16'd6000, 16'd1900, 16'd1700);
        // still above threshold, then gone exactly at threshold
        push_sample(16'd7001, 16'd0, 16'd0, 16'd0);
        push_sample(16'd7000, 16'd0, 16'd0, 16'd0);
        for (int k = 1; k < NUM_COLORS; k++)
        begin
            push_bright();
            push_bright();
            push_tinted(k, $urandom_range(65535, 100));
            push_dark();
        end
        drain();

        // Register sweeps, extremes first
        run_phase(0, 0, 1);
        run_phase(65535, 15, 3);
        run_phase(12000, 4, 0);
        run_phase(7000, 1, 2);
        run_phase(30000, 8, 1);
        run_phase($urandom_range(65535), $urandom_range(15), $urandom_range(3));

        repeat (SETTLE) @(posedge clk);
        if (errors == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule
